// ===== sv/pulse_rate_peak_detector_assert.svh =====
// Assertion macros for the pulse-rate peak detector.
`ifndef PULSE_RATE_PEAK_DETECTOR_ASSERT_SVH
`define PULSE_RATE_PEAK_DETECTOR_ASSERT_SVH
// Assert that an implication holds on every clock edge outside reset.
`define PRPD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Assert that the consequent holds in the cycle after the antecedent.
`define PRPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== sv/prpd_pkg.sv =====
// Package: constants, widths and types for the pulse-rate peak detector.
package prpd_pkg;
  localparam int SAMPLE_BITS_DEF = 18;
  localparam int IN_W   = 18;
  localparam int CFG_W  = 20;
  localparam int IDX_W  = 3;
  localparam int LVL_W  = 22;
  localparam int RATE_W = 13;
  localparam logic [15:0] NO_PEAK    = 16'd60000;
  localparam logic [12:0] RATE_MAX   = 13'd8191;
  localparam int          JUMP_LIMIT = 20000;

  typedef enum logic [2:0] {
    REG_THRESH   = 3'd0,
    REG_STAB     = 3'd1,
    REG_DEBOUNCE = 3'd2,
    REG_PERIOD   = 3'd3,
    REG_REFRACT  = 3'd4,
    REG_IMIN     = 3'd5,
    REG_IMAX     = 3'd6,
    REG_AMP      = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_STAB   = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_PEAK   = 2'd3
  } mode_t;

  typedef struct packed {
    logic        start;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [15:0] quot;
  } div_rsp_t;
endpackage

// ===== sv/pulse_rate_peak_detector.sv =====
// Top level: pulse-rate peak detector with contact tracking and serial rate divider.
// Each sample passes through accept, evaluate and hand to the output register, except a
// sample that completes a rate computation, which also waits in S_DIV for the 16-bit serial
// divider that computes 60000/interval. One result is produced per sample, and the
// next sample is taken while a result waits in the output register.
module pulse_rate_peak_detector #(
  parameter int SAMPLE_BITS = prpd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [23:0]               in_tdata,   // ir_sample[17:0], zero pad
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [15:0]               out_tdata,  // track_state[1:0], pulse_rate[14:2], rate_updated[15]
  input  logic                      cfg_we,
  input  logic [prpd_pkg::IDX_W-1:0] cfg_index,
  input  logic [prpd_pkg::CFG_W-1:0] cfg_data
);
  localparam int LW = prpd_pkg::LVL_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WORK = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } st_t;

  st_t st_r, st_nxt;
  logic [17:0] thr_r; logic [9:0] stab_r; logic [7:0] deb_r, per_r;
  logic [15:0] refr_r, imin_r, imax_r; logic [19:0] amp_r;

  logic [1:0] mode_r, mode_nxt;
  logic [9:0] mcnt_r, mcnt_nxt;
  logic [2:0] loss_r, loss_nxt;
  logic fst_r, fst_nxt, rose_r, rose_nxt, sst_r, sst_nxt;
  logic signed [LW-1:0] dc_r, dc_nxt, sm_r, sm_nxt, ps_r, ps_nxt, val_r, val_nxt;
  logic [7:0] rise_r, rise_nxt, fall_r, fall_nxt;
  logic [15:0] ivl_r, ivl_nxt;
  logic [12:0] rate_r, rate_nxt;
  logic [17:0] x_r, x_nxt;
  logic [15:0] res_r, res_nxt;
  logic [15:0] out_r, out_nxt;
  logic ov_r, ov_nxt;

  prpd_pkg::div_req_t dreq;
  prpd_pkg::div_rsp_t drsp;

  prpd_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic signed [LW-1:0] xs, dc1, d1, sm1, dfv, ampv, t1;
  logic [16:0] isum;
  logic [12:0] inst, diff;
  logic [14:0] avg;

  always_comb begin
    st_nxt = st_r;
    mode_nxt = mode_r; mcnt_nxt = mcnt_r; loss_nxt = loss_r;
    fst_nxt = fst_r; rose_nxt = rose_r; sst_nxt = sst_r;
    dc_nxt = dc_r; sm_nxt = sm_r; ps_nxt = ps_r; val_nxt = val_r;
    rise_nxt = rise_r; fall_nxt = fall_r; ivl_nxt = ivl_r; rate_nxt = rate_r;
    x_nxt = x_r; res_nxt = res_r; out_nxt = out_r; ov_nxt = ov_r;
    dreq = '{start: 1'b0, divisor: ivl_r};
    xs = LW'($signed({1'b0, x_r}));
    dc1 = '0; d1 = '0; sm1 = '0; dfv = '0; ampv = '0; t1 = '0; isum = '0;
    inst = '0; diff = '0; avg = '0;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    unique case (st_r)
      S_IDLE: if (in_tvalid) begin
        x_nxt = in_tdata[17:0] & 18'((19'd1 << SAMPLE_BITS) - 19'd1);
        st_nxt = S_WORK;
      end
      S_WORK: begin
        st_nxt = S_OUT;
        if (x_r < thr_r) begin
          if (mode_r != prpd_pkg::MODE_NONE) begin
            loss_nxt = loss_r + 3'd1;
            if (loss_nxt == 3'd5) mode_nxt = prpd_pkg::MODE_NONE;
          end else begin
            fst_nxt = 1'b0; rate_nxt = '0; loss_nxt = '0; mcnt_nxt = '0;
            sst_nxt = 1'b0; ivl_nxt = prpd_pkg::NO_PEAK;
          end
        end else begin
          loss_nxt = '0;
          case (mode_r)
            prpd_pkg::MODE_NONE: begin
              if (x_r > thr_r) begin
                mcnt_nxt = mcnt_r + 10'd1;
                if (mcnt_nxt == 10'd5) begin
                  mcnt_nxt = '0; mode_nxt = prpd_pkg::MODE_STAB;
                end
              end else mcnt_nxt = '0;
            end
            prpd_pkg::MODE_STAB: begin
              mcnt_nxt = mcnt_r + 10'd1;
              if (mcnt_nxt == stab_r) begin
                mcnt_nxt = '0; mode_nxt = prpd_pkg::MODE_SEARCH;
              end
            end
            prpd_pkg::MODE_SEARCH: begin
              if (!sst_r) begin
                ps_nxt = '0; rise_nxt = '0; fall_nxt = '0; rose_nxt = 1'b0;
                sst_nxt = 1'b1;
              end
              if (!fst_r) begin
                dc_nxt = xs; sm_nxt = '0; fst_nxt = 1'b1; sm1 = '0;
              end else begin
                dc1 = dc_r; sm1 = sm_r;
                if (xs - dc_r > LW'(prpd_pkg::JUMP_LIMIT)) begin
                  dc1 = xs; sm1 = '0;
                end
                dc1 = dc1 + ((xs - dc1) >>> 7);
                d1 = xs - dc1;
                sm1 = sm1 + ((d1 - sm1) >>> 2);
                dc_nxt = dc1; sm_nxt = sm1;
              end
              isum = {1'b0, ivl_r} + {9'd0, per_r};
              ivl_nxt = isum[16] ? 16'hFFFF : isum[15:0];
              dfv = sm1 - ps_nxt;
              ps_nxt = sm1;
              if (dfv > 0) begin
                if (rise_nxt != 8'hFF) rise_nxt = rise_nxt + 8'd1;
                if (rise_nxt >= deb_r) rose_nxt = 1'b1;
                if (fall_nxt != 8'd0) val_nxt = sm1;
                fall_nxt = '0;
              end else if (dfv < 0) begin
                if (fall_nxt != 8'hFF) fall_nxt = fall_nxt + 8'd1;
                rise_nxt = '0;
              end
              if (ivl_nxt >= refr_r && fall_nxt >= deb_r && rose_nxt) begin
                if (ivl_nxt >= prpd_pkg::NO_PEAK) begin
                  rise_nxt = '0; fall_nxt = '0; ivl_nxt = '0; rose_nxt = 1'b0;
                end else begin
                  t1 = sm1 - val_nxt;
                  ampv = (t1 < 0) ? -t1 : t1;
                  if (ivl_nxt >= imin_r && ivl_nxt <= imax_r &&
                      ampv >= LW'($signed({2'b0, amp_r}))) begin
                    mode_nxt = prpd_pkg::MODE_PEAK;
                  end else if (ivl_nxt >= imax_r) begin
                    rise_nxt = '0; fall_nxt = '0; ivl_nxt = '0; rose_nxt = 1'b0;
                  end
                end
              end
            end
            default: begin
              dreq.start = 1'b1;
              st_nxt = S_DIV;
            end
          endcase
        end
        if (st_nxt == S_OUT) res_nxt = {1'b0, rate_nxt, mode_nxt};
      end
      S_DIV: if (drsp.done) begin
        inst = (ivl_r == 16'd0 || drsp.quot > 16'(prpd_pkg::RATE_MAX)) ?
               prpd_pkg::RATE_MAX : drsp.quot[12:0];
        diff = (inst > rate_r) ? inst - rate_r : rate_r - inst;
        avg = 15'(({2'b0, rate_r} * 15'd3 + {2'b0, inst}) >> 2);
        if (rate_r == '0) rate_nxt = inst;
        else if (diff > (rate_r >> 2)) rate_nxt = rate_r;
        else rate_nxt = avg[12:0];
        rise_nxt = '0; fall_nxt = '0; ivl_nxt = '0; rose_nxt = 1'b0;
        mode_nxt = prpd_pkg::MODE_SEARCH;
        res_nxt = {1'b1, rate_nxt, prpd_pkg::MODE_SEARCH};
        st_nxt = S_OUT;
      end
      S_OUT: if (!ov_r || out_tready) begin
        ov_nxt = 1'b1; out_nxt = res_r; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt; res_r <= res_nxt; out_r <= out_nxt;
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0;
      thr_r <= 18'd1500; stab_r <= 10'd600; deb_r <= 8'd10; per_r <= 8'd10;
      refr_r <= 16'd300; imin_r <= 16'd300; imax_r <= 16'd1500; amp_r <= 20'd200;
      mode_r <= prpd_pkg::MODE_NONE; mcnt_r <= '0; loss_r <= '0;
      fst_r <= 1'b0; rose_r <= 1'b0; sst_r <= 1'b0;
      dc_r <= '0; sm_r <= '0; ps_r <= '0; val_r <= '0;
      rise_r <= '0; fall_r <= '0; ivl_r <= prpd_pkg::NO_PEAK; rate_r <= '0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt;
      mode_r <= mode_nxt; mcnt_r <= mcnt_nxt; loss_r <= loss_nxt;
      fst_r <= fst_nxt; rose_r <= rose_nxt; sst_r <= sst_nxt;
      dc_r <= dc_nxt; sm_r <= sm_nxt; ps_r <= ps_nxt; val_r <= val_nxt;
      rise_r <= rise_nxt; fall_r <= fall_nxt; ivl_r <= ivl_nxt; rate_r <= rate_nxt;
      if (cfg_we) begin
        unique case (prpd_pkg::reg_idx_t'(cfg_index))
          prpd_pkg::REG_THRESH:   thr_r  <= cfg_data[17:0];
          prpd_pkg::REG_STAB:     stab_r <= cfg_data[9:0];
          prpd_pkg::REG_DEBOUNCE: deb_r  <= cfg_data[7:0];
          prpd_pkg::REG_PERIOD:   per_r  <= cfg_data[7:0];
          prpd_pkg::REG_REFRACT:  refr_r <= cfg_data[15:0];
          prpd_pkg::REG_IMIN:     imin_r <= cfg_data[15:0];
          prpd_pkg::REG_IMAX:     imax_r <= cfg_data[15:0];
          default:                amp_r  <= cfg_data;
        endcase
      end
    end
  end

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = out_r;
endmodule

// ===== sv/prpd_div.sv =====
// Serial restoring divider: 60000 / divisor, one quotient bit per cycle.
module prpd_div (
  input  logic            clk,
  input  logic            rst_n,
  input  prpd_pkg::div_req_t req,
  output prpd_pkg::div_rsp_t rsp
);
  logic [15:0] q_r, q_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] d_r, d_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [16:0] sh;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    sh = {rem_r[15:0], q_r[15]};
    if (req.start) begin
      q_nxt = prpd_pkg::NO_PEAK; rem_nxt = '0; d_nxt = req.divisor;
      cnt_nxt = 5'd16; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, d_r}) begin
        rem_nxt = sh - {1'b0, d_r};
        q_nxt = {q_r[14:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt = {q_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt; rem_r <= rem_nxt; d_r <= d_nxt;
    if (!rst_n) begin
      cnt_r <= '0; busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt; busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end

  assign rsp = '{busy: busy_r, done: done_r, quot: q_r};
endmodule

// ===== sv/prpd_checker.sv =====
// Port-level checker for the pulse-rate peak detector, bound to the top level.
`include "pulse_rate_peak_detector_assert.svh"
module prpd_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);
  `PRPD_ASSERT_NEXT(a_in_busy, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `PRPD_ASSERT_IMP(a_upd_search, clk, rst_n, out_tvalid && out_tdata[15], out_tdata[1:0] == 2'd2)
  `PRPD_ASSERT_IMP(a_rate_max, clk, rst_n, out_tvalid, out_tdata[14:2] <= 13'd8191)
  `PRPD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
endmodule

bind pulse_rate_peak_detector prpd_port_checker u_prpd_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

// ===== tb/prpd_checker.sv =====
// Checker: mirrors the registers, predicts each result of the peak detector and compares.
module prpd_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [23:0]                in_tdata,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [15:0]                out_tdata,
  input  logic                       cfg_we,
  input  logic [prpd_pkg::IDX_W-1:0] cfg_index,
  input  logic [prpd_pkg::CFG_W-1:0] cfg_data,
  output int                         fail_count,
  output int                         results_due,
  output int                         rate_updates
);
  import prpd_pkg::*;

  typedef struct {
    mode_t       track;
    logic [12:0] rate;
    logic        updated;
  } beat_result_t;

  beat_result_t expected_beats[$];

  logic [17:0] thresh;
  logic [9:0]  stab_len;
  logic [7:0]  debounce, period;
  logic [15:0] refract, imin, imax;
  logic [19:0] amp_min;

  mode_t mode;
  int    mode_cnt, loss_cnt, dc, smooth, prev_smooth, valley;
  int    rises, falls, interval, rate;
  bit    filt_on, rose, search_on;

  task automatic clear_tracking();
    filt_on = 0; rate = 0; mode = MODE_NONE; loss_cnt = 0; mode_cnt = 0;
    search_on = 0; interval = NO_PEAK;
  endtask

  task automatic restart_slope();
    rises = 0; falls = 0; interval = 0; rose = 0;
  endtask

  task automatic search_peak(input int x, output bit done);
    int v, df, amp;
    done = 0;
    if (!search_on) begin
      prev_smooth = 0; rises = 0; falls = 0; search_on = 1; rose = 0;
    end
    if (!filt_on) begin
      dc = x; smooth = 0; filt_on = 1; v = 0;
    end else begin
      if (x - dc > JUMP_LIMIT) begin
        dc = x; smooth = 0;
      end
      dc = dc + ((x - dc) >>> 7);
      smooth = smooth + (((x - dc) - smooth) >>> 2);
      v = smooth;
    end
    interval = interval + period;
    if (interval > 65535) interval = 65535;
    df = v - prev_smooth;
    prev_smooth = v;
    if (df > 0) begin
      if (rises < 255) rises++;
      if (rises >= debounce) rose = 1;
      if (falls > 0) valley = v;
      falls = 0;
    end else if (df < 0) begin
      if (falls < 255) falls++;
      rises = 0;
    end
    if (interval < refract) return;
    if (falls >= debounce && rose) begin
      if (interval >= NO_PEAK) begin
        restart_slope();
        return;
      end
      amp = v - valley;
      if (amp < 0) amp = -amp;
      if (interval >= imin && interval <= imax && amp >= amp_min) mode = MODE_PEAK;
      else if (interval >= imax) restart_slope();
    end
  endtask

  task automatic update_rate();
    int inst, diff;
    inst = (interval == 0) ? RATE_MAX : 60000 / interval;
    if (inst > RATE_MAX) inst = RATE_MAX;
    diff = (inst > rate) ? inst - rate : rate - inst;
    if (rate == 0) rate = inst;
    else if (diff <= rate / 4) rate = (rate * 3 + inst) / 4;
    restart_slope();
    mode = MODE_SEARCH;
  endtask

  task automatic predict_beat(input int x);
    beat_result_t r;
    bit dummy;
    r.updated = 0;
    if (x < thresh) begin
      if (mode != MODE_NONE) begin
        loss_cnt = (loss_cnt + 1) & 7;
        if (loss_cnt == 5) mode = MODE_NONE;
      end else begin
        clear_tracking();
      end
    end else begin
      loss_cnt = 0;
      case (mode)
        MODE_NONE: begin
          if (x > thresh) begin
            mode_cnt = (mode_cnt + 1) & 10'h3FF;
            if (mode_cnt == 5) begin
              mode_cnt = 0; mode = MODE_STAB;
            end
          end else begin
            mode_cnt = 0;
          end
        end
        MODE_STAB: begin
          mode_cnt = (mode_cnt + 1) & 10'h3FF;
          if (mode_cnt == stab_len) begin
            mode_cnt = 0; mode = MODE_SEARCH;
          end
        end
        MODE_SEARCH: search_peak(x, dummy);
        default: begin
          update_rate();
          r.updated = 1;
        end
      endcase
    end
    r.track = mode;
    r.rate = rate[12:0];
    expected_beats.push_back(r);
  endtask

  always @(posedge clk) begin
    beat_result_t e;
    if (!rst_n) begin
      thresh = 1500; stab_len = 600; debounce = 10; period = 10;
      refract = 300; imin = 300; imax = 1500; amp_min = 200;
      clear_tracking();
      dc = 0; smooth = 0; prev_smooth = 0; valley = 0;
      rises = 0; falls = 0; rose = 0;
      expected_beats.delete();
      fail_count = 0;
      rate_updates = 0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_THRESH:   thresh   = cfg_data[17:0];
          REG_STAB:     stab_len = cfg_data[9:0];
          REG_DEBOUNCE: debounce = cfg_data[7:0];
          REG_PERIOD:   period   = cfg_data[7:0];
          REG_REFRACT:  refract  = cfg_data[15:0];
          REG_IMIN:     imin     = cfg_data[15:0];
          REG_IMAX:     imax     = cfg_data[15:0];
          REG_AMP:      amp_min  = cfg_data[19:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_beat(int'(in_tdata[17:0]));
      if (out_tvalid && out_tready) begin
        if (expected_beats.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected transfer: %h", out_tdata);
        end else begin
          e = expected_beats.pop_front();
          if (e.updated) rate_updates++;
          if (out_tdata[1:0] !== e.track || out_tdata[14:2] !== e.rate ||
              out_tdata[15] !== e.updated) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: state exp %0d got %0d, rate exp %0d got %0d, upd exp %0d got %0d",
                       e.track, out_tdata[1:0], e.rate, out_tdata[14:2],
                       e.updated, out_tdata[15]);
          end
        end
      end
    end
    results_due = expected_beats.size();
  end
endmodule

// ===== tb/testbench.sv =====
// Testbench top: drives samples and register writes into the peak detector and reports the verdict.
module testbench;
  import prpd_pkg::*;

  localparam int STALL_LIMIT = 5000;

  logic                 clk = 0;
  logic                 rst_n = 0;
  logic                 in_tvalid = 0;
  logic                 in_tready;
  logic [23:0]          in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 0;
  logic [15:0]          out_tdata;
  logic                 cfg_we = 0;
  logic [IDX_W-1:0]     cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  int                   fail_count, results_due, rate_updates;
  int                   samples_sent = 0;
  int                   send_idle_pct = 24, recv_idle_pct = 86;
  int                   hold_cycles = 0;
  bit                   hold_req = 0;
  int                   quiet_cycles = 0;

  always #4 clk = ~clk;

  pulse_rate_peak_detector u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  prpd_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .results_due(results_due), .rate_updates(rate_updates)
  );

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req && hold_cycles == 0) begin
      hold_cycles <= 400;
      hold_req <= 0;
      out_tready <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_sample(input logic [17:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {6'b0, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    samples_sent++;
    if (samples_sent == 480) begin
      send_idle_pct = 86; recv_idle_pct = 24;
    end else if (samples_sent == 700) begin
      hold_req = 1;
    end else if (samples_sent == 960) begin
      send_idle_pct = 0; recv_idle_pct = 0;
    end
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_regs(input logic [17:0] th, input logic [9:0] st, input logic [7:0] db,
                           input logic [7:0] pe, input logic [15:0] rf, input logic [15:0] lo,
                           input logic [15:0] hi, input logic [19:0] am);
    logic [CFG_W-1:0] vals [8];
    drain();
    vals = '{20'(th), 20'(st), 20'(db), 20'(pe), 20'(rf), 20'(lo), 20'(hi), am};
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1;
      cfg_index <= IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic int tri_wave(input int t, input int per, input int amp);
    int p, half;
    half = per / 2;
    p = t % per;
    return (p < half) ? amp * p / half : amp * (per - p) / half;
  endfunction

  task automatic pulse_run(input int len, input int base);
    int per, amp, v;
    per = $urandom_range(90, 40);
    amp = $urandom_range(15000, 800);
    for (int t = 0; t < len; t++) begin
      v = base + tri_wave(t, per, amp) + $urandom_range(40);
      if ($urandom_range(99) == 0) v = v + 25000;
      send_sample(18'(v > 262143 ? 262143 : v));
    end
  endtask

  initial begin
    int base, len;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: contact edges, threshold equality, field extremes
    send_sample(18'd0);
    send_sample(18'h3FFFF);
    send_sample(18'd1500);
    send_sample(18'd1499);
    repeat (5) send_sample(18'd1501);
    send_sample(18'd1500);
    repeat (5) send_sample(18'd0);
    repeat (3) send_sample(18'h2AAAA);
    send_sample(18'h15555);

    // low extremes: no threshold, immediate slopes, tight interval
    load_regs(18'd0, 10'd1, 8'd0, 8'd1, 16'd0, 16'd10, 16'd10, 20'd0);
    pulse_run(60, 1000);
    send_sample(18'd0);
    // high extremes
    load_regs(18'h3FFFF, 10'd1023, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF);
    repeat (7) send_sample(18'h3FFFF);
    send_sample(18'h3FFFE);
    send_sample(18'd0);

    while (samples_sent < 1450) begin
      case ($urandom_range(4))
        0: load_regs(18'd1500, 10'($urandom_range(30, 1)), 8'($urandom_range(4, 1)), 8'd10,
                     16'd300, 16'd300, 16'd1500, 20'd200);
        1: load_regs(18'($urandom_range(20000)), 10'($urandom_range(10, 1)),
                     8'($urandom_range(3)), 8'($urandom_range(40, 1)),
                     16'($urandom_range(800)), 16'($urandom_range(400, 10)),
                     16'($urandom_range(3000, 400)), 20'($urandom_range(3000)));
        2: load_regs(18'd5000, 10'd0, 8'd2, 8'd255, 16'd0, 16'd10, 16'hFFFF, 20'd0);
        default: load_regs(18'd2000, 10'($urandom_range(20, 1)), 8'($urandom_range(6, 1)),
                           8'($urandom_range(20, 5)), 16'd200, 16'd250, 16'd2000,
                           20'($urandom_range(500)));
      endcase
      for (int s = 0; s < 3 && samples_sent < 1450; s++) begin
        if ($urandom_range(99) < 75) begin
          base = $urandom_range(200000, 30000);
          len = $urandom_range(250, 80);
          if (len > 1450 - samples_sent) len = 1450 - samples_sent;
          pulse_run(len, base);
          repeat ($urandom_range(8, 1)) send_sample(18'($urandom_range(1400)));
        end else begin
          repeat ($urandom_range(30, 5)) send_sample(18'($urandom));
        end
      end
    end

    drain();
    repeat (40) @(posedge clk);
    $display("Sent %0d samples over several register settings and idle patterns;", samples_sent);
    $display("%0d rate computations were checked.", rate_updates);
    if (fail_count == 0 && results_due == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+sv
sv/prpd_pkg.sv
sv/prpd_div.sv
sv/pulse_rate_peak_detector.sv
sv/prpd_checker.sv
tb/prpd_checker.sv
tb/testbench.sv
